/* rtl/wfr_pkg.sv */
package wfr_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CODE_W = 32;
    localparam int unsigned TYPE_W = 6;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned IDLE_W = 20;

    localparam logic [CNT_W-1:0]  CNT_MAX    = 6'd63;
    localparam logic [CNT_W-1:0]  CNT_WORD   = 6'd31;
    localparam logic [IDLE_W-1:0] IDLE_RESET = 20'd25000;

    // frame lengths that decode
    localparam logic [CNT_W-1:0] LEN_KEY4  = 6'd4;
    localparam logic [CNT_W-1:0] LEN_KEY8  = 6'd8;
    localparam logic [CNT_W-1:0] LEN_ID24  = 6'd24;
    localparam logic [CNT_W-1:0] LEN_ID26  = 6'd26;
    localparam logic [CNT_W-1:0] LEN_ID32  = 6'd32;
    localparam logic [CNT_W-1:0] LEN_ID34  = 6'd34;

    localparam logic [3:0]        KEY_STAR   = 4'hb;
    localparam logic [3:0]        KEY_HASH   = 4'ha;
    localparam logic [CODE_W-1:0] KEY_ENTER  = 32'h0000_000d;
    localparam logic [CODE_W-1:0] KEY_ESCAPE = 32'h0000_001b;

    typedef enum logic [1:0] {
        OP_D0   = 2'd0,
        OP_D1   = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_DECODED  = 2'd1,
        ST_REJECTED = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0]      shift_low;
        logic [31:0]      shift_high;
        logic [CNT_W-1:0] bit_count;
    } frame_t;

    typedef struct packed {
        logic              ready;
        status_t           status;
        logic              load_code;
        logic              load_type;
        logic [CODE_W-1:0] code;
        logic [TYPE_W-1:0] frame_type;
    } decode_t;

    function automatic logic [CODE_W-1:0] map_key(input logic [3:0] k);
        logic [CODE_W-1:0] r;
        if (k == KEY_STAR) begin
            r = KEY_ENTER;
        end else if (k == KEY_HASH) begin
            r = KEY_ESCAPE;
        end else begin
            r = {{(CODE_W-4){1'b0}}, k};
        end
        return r;
    endfunction

endpackage

/* rtl/wfr_frame_acc.sv */
module wfr_frame_acc (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            take_bit,
    input  logic            bit_value,
    input  logic            clear,
    output wfr_pkg::frame_t frame
);
    import wfr_pkg::*;

    logic [31:0]      shift_low_reg,  shift_low_next;
    logic [31:0]      shift_high_reg, shift_high_next;
    logic [CNT_W-1:0] bit_count_reg,  bit_count_next;

    always_comb begin
        shift_low_next  = shift_low_reg;
        shift_high_next = shift_high_reg;
        bit_count_next  = bit_count_reg;
        if (clear) begin
            shift_low_next  = '0;
            shift_high_next = '0;
            bit_count_next  = '0;
        end else if (take_bit) begin
            if (bit_count_reg != CNT_MAX) begin
                bit_count_next = bit_count_reg + 6'd1;
            end
            // from the 32nd bit on the low word spills into the high word
            if (bit_count_next > CNT_WORD) begin
                shift_high_next = {shift_high_reg[30:1],
                                   shift_high_reg[0] | shift_low_reg[31], 1'b0};
            end
            shift_low_next = {shift_low_reg[30:1], shift_low_reg[0] | bit_value, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_low_reg  <= '0;
            shift_high_reg <= '0;
            bit_count_reg  <= '0;
        end else begin
            shift_low_reg  <= shift_low_next;
            shift_high_reg <= shift_high_next;
            bit_count_reg  <= bit_count_next;
        end
    end

    assign frame.shift_low  = shift_low_reg;
    assign frame.shift_high = shift_high_reg;
    assign frame.bit_count  = bit_count_reg;

endmodule

/* rtl/wfr_decode.sv */
module wfr_decode (
    input  wfr_pkg::frame_t                   frame,
    input  logic [wfr_pkg::CNT_W-1:0]         count_at_last_poll,
    input  logic [wfr_pkg::TIME_W-1:0]        last_poll_time,
    input  logic [wfr_pkg::TIME_W-1:0]        now_us,
    input  logic [wfr_pkg::IDLE_W-1:0]        idle_wait_us,
    output wfr_pkg::decode_t                  dec
);
    import wfr_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic [31:0]       lo;
    logic [31:0]       hi;
    logic [3:0]        low_nib;
    logic [3:0]        high_nib;
    logic [CNT_W-1:0]  n;

    assign n        = frame.bit_count;
    assign elapsed  = now_us - last_poll_time;
    // undo the pre-shift of the receive pair
    assign lo       = {1'b0, frame.shift_low[31:1]};
    assign hi       = {1'b0, frame.shift_high[31:1]};
    assign low_nib  = lo[3:0];
    assign high_nib = lo[7:4];

    always_comb begin
        dec            = '0;
        dec.status     = ST_NONE;
        dec.ready      = (elapsed > {{(TIME_W-IDLE_W){1'b0}}, idle_wait_us})
                         && (n != '0) && (n == count_at_last_poll);
        dec.frame_type = n;
        if (dec.ready) begin
            if (n inside {LEN_KEY4, LEN_KEY8, LEN_ID24, LEN_ID26, LEN_ID32, LEN_ID34}) begin
                dec.load_type = 1'b1;
                dec.load_code = 1'b1;
                dec.status    = ST_DECODED;
                if (n == LEN_KEY4) begin
                    dec.code = map_key(low_nib);
                end else if (n == LEN_KEY8) begin
                    dec.code = map_key(low_nib);
                    if (low_nib != ~high_nib) begin
                        dec.load_code = 1'b0;
                        dec.status    = ST_REJECTED;
                    end
                end else if (n == LEN_ID26) begin
                    dec.code = {8'd0, lo[24:1]};
                end else if (n == LEN_ID34) begin
                    dec.code = {hi[1:0], lo[30:1]};
                end else begin
                    dec.code = lo;
                end
            end else begin
                dec.status = ST_REJECTED;
            end
        end
    end

endmodule

/* rtl/wiegand_frame_receiver.sv */
// Wiegand receiver for keypads and card readers. Each transaction on the s_axis
// side is a D0 pulse, a D1 pulse or a poll carrying the microsecond time. It goes
// through an input register and then one pass of decode logic, and while m_axis
// keeps up a new one is taken every cycle. Pulses give no output and keep moving
// while a result waits. A poll needs the output register, so a poll that sits
// behind a stalled result holds s_axis_tready low until that result is taken.
// A poll's result passes the input register and then the output register, and a
// stalled result in the output register holds the poll back. The result carries
// status none, decoded or rejected, plus the last decoded code and frame
// length. A frame completes at a poll that finds the bit count nonzero and
// unchanged and more than idle_wait_us gone since the previous poll; 4 and 8 bit
// keys and 24/26/32/34 bit card ids decode, other lengths are dropped.
module wiegand_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,     // idle_wait_us
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] now_us
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] card_code, [37:32] frame_bits, zero fill
    output logic [1:0]  m_axis_tuser   // [1:0] status
);
    import wfr_pkg::*;

    logic [IDLE_W-1:0] idle_wait_reg;
    logic              in_valid_reg;
    logic [1:0]        in_op_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic [TIME_W-1:0] last_poll_time_reg;
    logic [CNT_W-1:0]  count_at_last_poll_reg;
    logic [CODE_W-1:0] held_code_reg, held_code_next;
    logic [TYPE_W-1:0] held_type_reg, held_type_next;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [CODE_W-1:0] m_code_reg;
    logic [TYPE_W-1:0] m_type_reg;

    logic    is_poll;
    logic    is_pulse;
    logic    fire;
    logic    do_poll;
    frame_t  frame;
    decode_t dec;

    assign is_poll  = (in_op_reg == OP_POLL);
    assign is_pulse = (in_op_reg == OP_D0) || (in_op_reg == OP_D1);
    // a pulse never needs the output slot
    assign fire     = in_valid_reg && (!is_poll || !m_valid_reg || m_axis_tready);
    assign do_poll  = fire && is_poll;
    assign s_axis_tready = !in_valid_reg || fire;

    wfr_frame_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take_bit  (fire && is_pulse),
        .bit_value (in_op_reg == OP_D1),
        .clear     (do_poll && dec.ready),
        .frame     (frame)
    );

    wfr_decode u_dec (
        .frame              (frame),
        .count_at_last_poll (count_at_last_poll_reg),
        .last_poll_time     (last_poll_time_reg),
        .now_us             (in_now_reg),
        .idle_wait_us       (idle_wait_reg),
        .dec                (dec)
    );

    assign held_code_next = dec.load_code ? dec.code : held_code_reg;
    assign held_type_next = dec.load_type ? dec.frame_type : held_type_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_wait_reg          <= IDLE_RESET;
            in_valid_reg           <= 1'b0;
            last_poll_time_reg     <= '0;
            count_at_last_poll_reg <= '0;
            held_code_reg          <= '0;
            held_type_reg          <= '0;
            m_valid_reg            <= 1'b0;
        end else begin
            if (cfg_we) begin
                idle_wait_reg <= cfg_wdata;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (do_poll) begin
                last_poll_time_reg     <= in_now_reg;
                count_at_last_poll_reg <= dec.ready ? '0 : frame.bit_count;
                held_code_reg          <= held_code_next;
                held_type_reg          <= held_type_next;
                m_valid_reg            <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg  <= s_axis_tuser;
            in_now_reg <= s_axis_tdata;
        end
        if (do_poll) begin
            m_status_reg <= dec.status;
            m_code_reg   <= held_code_next;
            m_type_reg   <= held_type_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {2'b00, m_type_reg, m_code_reg};

endmodule

/* rtl/wfr_checker.sv */
module wfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import wfr_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == ST_NONE || m_axis_tuser == ST_DECODED
            || m_axis_tuser == ST_REJECTED))
        else $error("bad status code");

    a_frame_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[37:32] == 6'd0 || m_axis_tdata[37:32] == LEN_KEY4
            || m_axis_tdata[37:32] == LEN_KEY8 || m_axis_tdata[37:32] == LEN_ID24
            || m_axis_tdata[37:32] == LEN_ID26 || m_axis_tdata[37:32] == LEN_ID32
            || m_axis_tdata[37:32] == LEN_ID34))
        else $error("frame length outside decodable set");

    a_decoded_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == ST_DECODED |-> m_axis_tdata[37:32] != 6'd0)
        else $error("decoded frame without length");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind wiegand_frame_receiver wfr_checker u_wfr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/wiegand_frame_receiver_check.sv */
module wiegand_frame_receiver_check
    import wfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,     // idle_wait_us
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] now_us
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,  // [31:0] card_code, [37:32] frame_bits, zero fill
    input  logic [1:0]  m_axis_tuser,  // [1:0] status
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t           status;
        logic [CODE_W-1:0] code;
        logic [TYPE_W-1:0] bits;
    } poll_result_t;

    logic [IDLE_W-1:0] wait_limit;
    logic [31:0]       rx_low;
    logic [31:0]       rx_high;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  count_seen;
    logic [TIME_W-1:0] prev_poll_us;
    logic [CODE_W-1:0] last_code;
    logic [TYPE_W-1:0] last_len;

    poll_result_t polls_due[$];
    int           mismatches;

    function automatic logic [CODE_W-1:0] keypad_code(input logic [3:0] key);
        case (key)
            KEY_STAR: return KEY_ENTER;
            KEY_HASH: return KEY_ESCAPE;
            default:  return {28'd0, key};
        endcase
    endfunction

    function automatic void clear_frame();
        rx_low     = '0;
        rx_high    = '0;
        rx_count   = '0;
        count_seen = '0;
    endfunction

    function automatic void shift_in(input logic b);
        if (rx_count < CNT_MAX) rx_count++;
        // beyond one word the top bit of the low half carries into the high half
        if (rx_count > CNT_WORD) rx_high = (rx_high | rx_low[31]) << 1;
        rx_low = (rx_low | b) << 1;
    endfunction

    function automatic poll_result_t decode_poll(input logic [TIME_W-1:0] now);
        logic [31:0]       elapsed;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [CNT_W-1:0]  n;
        logic [TYPE_W-1:0] old_len;
        logic              ready;
        poll_result_t      r;
        elapsed      = now - prev_poll_us;
        n            = rx_count;
        ready        = (elapsed > {12'd0, wait_limit}) && (n != '0) && (n == count_seen);
        prev_poll_us = now;
        count_seen   = n;
        r.status     = ST_NONE;
        if (ready) begin
            lo       = rx_low >> 1;
            hi       = (n > 6'd32) ? rx_high >> 1 : rx_high;
            old_len  = last_len;
            last_len = n;
            r.status = ST_DECODED;
            case (n)
                LEN_KEY4: begin
                    last_code = keypad_code(lo[3:0]);
                end
                LEN_KEY8: begin
                    // type sticks even when the nibble check fails
                    if (lo[3:0] == ~lo[7:4]) begin
                        last_code = keypad_code(lo[3:0]);
                    end else begin
                        r.status = ST_REJECTED;
                    end
                end
                LEN_ID26: begin
                    last_code = {8'd0, lo[24:1]};
                end
                LEN_ID34: begin
                    last_code = {hi[1:0], lo[30:1]};
                end
                LEN_ID24, LEN_ID32: begin
                    last_code = lo;
                end
                default: begin
                    r.status = ST_REJECTED;
                    last_len = old_len;
                end
            endcase
            clear_frame();
        end
        r.code = last_code;
        r.bits = last_len;
        return r;
    endfunction

    always @(posedge aclk) begin
        poll_result_t want;
        poll_result_t got;
        if (!aresetn) begin
            wait_limit   = IDLE_RESET;
            prev_poll_us = '0;
            last_code    = '0;
            last_len     = '0;
            clear_frame();
            polls_due.delete();
        end else begin
            if (cfg_we) wait_limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    OP_D0:   shift_in(1'b0);
                    OP_D1:   shift_in(1'b1);
                    OP_POLL: polls_due.push_back(decode_poll(s_axis_tdata));
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = status_t'(m_axis_tuser);
                got.code   = m_axis_tdata[31:0];
                got.bits   = m_axis_tdata[37:32];
                if (polls_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: status %0d code %h bits %0d",
                                 got.status, got.code, got.bits);
                end else begin
                    want = polls_due.pop_front();
                    if (got.status !== want.status || got.code !== want.code ||
                        got.bits !== want.bits) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"poll result mismatch: expected status %0d code %h ",
                                      "bits %0d, got status %0d code %h bits %0d"},
                                     want.status, want.code, want.bits,
                                     got.status, got.code, got.bits);
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= polls_due.size();
    end

endmodule

/* verif/wiegand_frame_receiver_test.sv */
module wiegand_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wfr_pkg::*;

    localparam logic [1:0]        OP_UNUSED     = 2'd3;
    localparam logic [IDLE_W-1:0] WAIT_MAX      = 20'd1000000;
    localparam int                PHASE_ITEMS   = 250;
    localparam int                HOLD_CYCLES   = 300;
    localparam int                SETTLE_CYCLES = 4;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [19:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int                fail_count;
    int                pending;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                items_sent;
    bit                hold_req;
    logic [TIME_W-1:0] clock_us;
    logic [IDLE_W-1:0] wait_us;
    int                valid_lens[6] = '{4, 8, 24, 26, 32, 34};

    wiegand_frame_receiver i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    wiegand_frame_receiver_check i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("wiegand_frame_receiver_test failed");
        $finish;
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] stamp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= stamp;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic poll_after(input logic [31:0] gap);
        clock_us += gap;
        send_item(OP_POLL, clock_us);
    endtask

    // first bit sent lands in the top position of the frame
    task automatic send_frame(input int len, input logic [63:0] pattern, input bit at_limit);
        for (int i = len - 1; i >= 0; i--)
            send_item(pattern[i % 64] ? OP_D1 : OP_D0, $urandom());
        poll_after($urandom_range(50));
        // quiet for exactly the wait time does not complete the frame
        if (at_limit || $urandom_range(3) == 0) poll_after(32'(wait_us));
        poll_after(32'(wait_us) + 32'd1 + $urandom_range(2000));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_wait(input logic [IDLE_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        wait_us   = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int target);
        int          stop;
        int          pick;
        int          len;
        logic [1:0]  op;
        logic [63:0] pattern;
        stop = items_sent + target;
        while (items_sent < stop) begin
            pick    = $urandom_range(99);
            pattern = {$urandom(), $urandom()};
            if (pick < 65) begin
                len = valid_lens[$urandom_range(5)];
                if (len == 8 && $urandom_range(1)) pattern[3:0] = ~pattern[7:4];
                send_frame(len, pattern, 1'b0);
            end else if (pick < 80) begin
                send_frame($urandom_range(70, 1), pattern, 1'b0);
            end else if (pick < 90) begin
                // a poll long after the previous one but while bits still arrive
                repeat ($urandom_range(12, 1))
                    send_item($urandom_range(1) ? OP_D1 : OP_D0, $urandom());
                poll_after(32'(wait_us) + 32'd1 + $urandom_range(100));
                send_frame(valid_lens[$urandom_range(5)], pattern, 1'b0);
            end else begin
                repeat ($urandom_range(8, 1)) begin
                    op = 2'($urandom_range(3));
                    if (op == OP_POLL) begin
                        if ($urandom_range(1)) clock_us = $urandom();
                        else clock_us += $urandom_range(2 * wait_us + 2);
                        send_item(op, clock_us);
                    end else begin
                        send_item(op, $urandom());
                    end
                end
                poll_after(32'd1);
                poll_after(32'(wait_us) + 32'd1);
            end
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        hold_req      = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        items_sent    = 0;
        clock_us      = '0;
        wait_us       = IDLE_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_frame(LEN_KEY4, KEY_STAR, 1'b1);
        // completing poll wraps the microsecond counter
        clock_us = 32'hFFFF_FF00;
        send_frame(LEN_KEY4, KEY_HASH, 1'b0);
        // high nibble 3, low nibble 5: complement check fails
        send_frame(LEN_KEY8, 64'h35, 1'b0);
        send_item(OP_UNUSED, $urandom());
        poll_after(32'hFFFF_FFFF);

        tx_idle_pct = 37;
        rx_idle_pct = 75;
        write_wait('0);
        run_phase(PHASE_ITEMS);

        tx_idle_pct = 75;
        rx_idle_pct = 37;
        write_wait(WAIT_MAX);
        run_phase(PHASE_ITEMS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_wait(IDLE_W'($urandom_range(WAIT_MAX)));
        hold_req = 1'b1;
        repeat (16) poll_after(32'd1);
        run_phase(PHASE_ITEMS);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("wiegand_frame_receiver_test passed");
        end else begin
            $display("wiegand_frame_receiver_test failed");
        end
        $finish;
    end

endmodule

/* wiegand_frame_receiver.f */
rtl/wfr_pkg.sv
rtl/wfr_frame_acc.sv
rtl/wfr_decode.sv
rtl/wiegand_frame_receiver.sv
rtl/wfr_checker.sv
verif/wiegand_frame_receiver_check.sv
verif/wiegand_frame_receiver_test.sv
